[rtl/bc_pkg.sv]
package bc_pkg;

  typedef enum logic [1:0] {
    VERDICT_BIPARTITE = 2'd0,
    VERDICT_CONFLICT  = 2'd1,
    VERDICT_INVALID   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    COL_NONE   = 2'd0,
    COL_FIRST  = 2'd1,
    COL_SECOND = 2'd2
  } colour_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RANGE,
    ST_RANGE_CHK,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_EDGE,
    ST_EDGE_CHK,
    ST_VISIT,
    ST_CLEAR,
    ST_OUT
  } state_t;

  localparam int unsigned VID_W = 8;

endpackage

[rtl/bc_if.sv]
interface bc_in_if;
  logic       valid;
  logic       ready;
  logic       has_edge;
  logic [7:0] edge_from;
  logic [7:0] edge_to;
  logic       last;
  modport source (output valid, has_edge, edge_from, edge_to, last, input ready);
  modport sink (input valid, has_edge, edge_from, edge_to, last, output ready);
endinterface

interface bc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

interface bc_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

[rtl/bipartite_check.sv]
// Graph two-coloring checker. Edges load one word per cycle into an edge
// memory; the word with last set starts the check, during which no word is
// accepted. The check runs a range pass over the edges, then for every
// vertex a color lookup, and for each vertex popped from the work
// stack a full pass over the edge memory (with an extra visit step when an
// edge touches the popped vertex), all paced by the registered reads of the
// edge and color memories. After the verdict a clearing pass over all
// MAX_VERTICES entries resets the color memory before the next word; the
// same pass runs right after reset; the first word is taken only after it.
module bipartite_check import bc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_EDGES    = 1024
) (
  input  logic clk,
  input  logic rst,
  bc_cfg_if.sink  cfg,
  bc_in_if.sink   in_ch,
  bc_out_if.source out_ch
);

  localparam int unsigned VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EC = $clog2(MAX_EDGES + 1);
  localparam int unsigned VC = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SD = $clog2(MAX_VERTICES + 1);

  state_t state, state_next;
  logic [8:0]      vertex_count;
  logic [EC-1:0]   edge_count;
  logic            invalid_flag;
  logic            conflict_flag;
  logic [EC-1:0]   eidx;
  logic [VC-1:0]   vidx;
  logic [SD-1:0]   stack_depth;
  logic [VA-1:0]   cur_v;
  colour_t         cur_col;
  logic [VA-1:0]   nb;
  logic [1:0]      verdict;
  logic [VC-1:0]   nv;

  // edge memory
  logic          e_we;
  logic [EA-1:0] e_waddr, e_raddr;
  logic [15:0]   e_wdata, e_rdata;
  // color memory
  logic          c_we;
  logic [VA-1:0] c_waddr, c_raddr;
  logic [1:0]    c_wdata, c_rdata;
  // stack memory
  logic          s_we;
  logic [VA-1:0] s_waddr, s_raddr;
  logic [VA-1:0] s_wdata, s_rdata;

  bc_ram #(.DEPTH(MAX_EDGES), .WIDTH(16)) u_edges (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));
  bc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(2)) u_colours (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));
  bc_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VA)) u_stack (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));

  // effective vertex count, saturated
  always_comb begin
    if (32'(vertex_count) > MAX_VERTICES) nv = VC'(MAX_VERTICES);
    else nv = VC'(vertex_count);
  end

  logic [7:0] ea, eb;
  logic       edge_done, in_fire;
  assign ea = e_rdata[15:8];
  assign eb = e_rdata[7:0];
  assign edge_done = (eidx == edge_count);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == ST_LOAD);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.verdict = verdict;

  // memory port addressing
  always_comb begin
    e_we    = in_fire && in_ch.has_edge && (32'(edge_count) < MAX_EDGES);
    e_waddr = EA'(edge_count);
    e_wdata = {in_ch.edge_from, in_ch.edge_to};
    e_raddr = EA'(eidx);
    c_raddr = VA'(vidx);
    if (state == ST_POP_WAIT) c_raddr = s_rdata;
    else if (state == ST_EDGE_CHK) c_raddr = nb;
    s_raddr = VA'(stack_depth - SD'(1));
  end

  // neighbor from the edge just read
  always_comb begin
    nb = cur_v;
    if (32'(ea) < MAX_VERTICES && VA'(ea) == cur_v && {{(32-VA){1'b0}}, cur_v} == 32'(ea))
      nb = VA'(eb);
    else if (32'(eb) < MAX_VERTICES && 32'(eb) == 32'(cur_v))
      nb = VA'(ea);
  end

  logic hit;
  assign hit = (32'(ea) == 32'(cur_v)) || (32'(eb) == 32'(cur_v));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (in_fire && in_ch.last) state_next = ST_RANGE;
      ST_RANGE:     state_next = invalid_flag ? ST_OUT : (edge_done ? ST_SCAN : ST_RANGE_CHK);
      ST_RANGE_CHK: state_next = (VC'(ea) >= nv || VC'(eb) >= nv) ? ST_OUT : ST_RANGE;
      ST_SCAN:      state_next = (vidx == nv || conflict_flag) ? ST_OUT : ST_SCAN_CHK;
      ST_SCAN_CHK:  state_next = (c_rdata == COL_NONE) ? ST_POP : ST_SCAN;
      ST_POP:       state_next = (stack_depth == '0 || conflict_flag) ? ST_SCAN : ST_POP_WAIT;
      ST_POP_WAIT:  state_next = ST_EDGE;
      ST_EDGE:      state_next = (edge_done || conflict_flag) ? ST_POP : ST_EDGE_CHK;
      ST_EDGE_CHK:  state_next = hit ? ST_VISIT : ST_EDGE;
      ST_VISIT:     state_next = ST_EDGE;
      ST_OUT:       if (out_ch.ready) state_next = ST_CLEAR;
      ST_CLEAR:     if (vidx == VC'(MAX_VERTICES - 1)) state_next = ST_LOAD;
      default:      state_next = ST_LOAD;
    endcase
  end

  // clear the color memory first after reset
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // datapath and memory writes
  always_comb begin
    c_we = 1'b0; c_waddr = VA'(vidx); c_wdata = COL_NONE;
    s_we = 1'b0; s_waddr = VA'(stack_depth); s_wdata = VA'(vidx);
    unique case (state)
      ST_SCAN_CHK: if (c_rdata == COL_NONE) begin
        c_we = 1'b1; c_wdata = COL_FIRST;
        s_we = 1'b1; s_waddr = '0;
      end
      ST_VISIT: if (c_rdata == COL_NONE) begin
        c_we = 1'b1; c_waddr = nb; c_wdata = 2'(3 - int'(cur_col));
        s_we = (32'(stack_depth) < MAX_VERTICES); s_wdata = nb;
      end
      ST_CLEAR: c_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 9'd1;
      edge_count <= '0; invalid_flag <= 1'b0; conflict_flag <= 1'b0;
      eidx <= '0; vidx <= '0; stack_depth <= '0; verdict <= VERDICT_BIPARTITE;
      cur_v <= '0; cur_col <= COL_NONE;
    end else begin
      if (cfg.valid) vertex_count <= cfg.vertex_count;
      unique case (state)
        ST_LOAD: if (in_fire) begin
          if (in_ch.has_edge) begin
            if (32'(edge_count) < MAX_EDGES) edge_count <= edge_count + EC'(1);
            else invalid_flag <= 1'b1;
          end
          eidx <= '0;
        end
        ST_RANGE: begin
          verdict <= VERDICT_INVALID;
          if (edge_done) vidx <= '0;
        end
        ST_RANGE_CHK: eidx <= eidx + EC'(1);
        ST_SCAN: verdict <= conflict_flag ? VERDICT_CONFLICT : VERDICT_BIPARTITE;
        ST_SCAN_CHK: begin
          if (c_rdata == COL_NONE) stack_depth <= SD'(1);
          else vidx <= vidx + VC'(1);
        end
        ST_POP: begin
          if (stack_depth == '0 || conflict_flag) vidx <= vidx + VC'(1);
          else stack_depth <= stack_depth - SD'(1);
        end
        ST_POP_WAIT: begin
          cur_v <= s_rdata;
          eidx <= '0;
        end
        ST_EDGE: if (eidx == '0 && !edge_done) cur_col <= colour_t'(c_rdata);
        ST_EDGE_CHK: if (!hit) eidx <= eidx + EC'(1);
        ST_VISIT: begin
          eidx <= eidx + EC'(1);
          if (c_rdata == COL_NONE) begin
            if (32'(stack_depth) < MAX_VERTICES) stack_depth <= stack_depth + SD'(1);
          end else if (c_rdata == cur_col) conflict_flag <= 1'b1;
        end
        ST_OUT: if (out_ch.ready) begin
          vidx <= '0;
          edge_count <= '0; invalid_flag <= 1'b0; conflict_flag <= 1'b0;
          stack_depth <= '0;
        end
        ST_CLEAR: vidx <= vidx + VC'(1);
        default: ;
      endcase
    end
  end

  // color read address: popped vertex at pop wait, nb at edge check,
  // vidx otherwise (color of cur_v arrives during the first edge cycle)

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("input open during verdict");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.verdict))
    else $error("verdict dropped");
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.verdict != 2'd3) else $error("bad verdict code");

endmodule

[rtl/bc_ram.sv]
module bc_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
